@@ design/kfca_pkg.sv @@
// Shared constants, types and helper functions of the constant-acceleration Kalman filter.
`default_nettype none

package kfca_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int STATE_COUNT = 3;

	localparam int QW      = 32 + FRAC_BITS;
	localparam int QCNT_W  = $clog2(QW + 1);

	localparam int AW            = 6;
	localparam int RAM_DEPTH     = 33;
	localparam int STATE_ENTRIES = 12;
	localparam int SE_W          = 4;

	localparam logic [AW-1:0] X_BASE  = AW'(0);
	localparam logic [AW-1:0] P_BASE  = AW'(3);
	localparam logic [AW-1:0] XP_BASE = AW'(12);
	localparam logic [AW-1:0] T_BASE  = AW'(15);
	localparam logic [AW-1:0] PP_BASE = AW'(24);

	localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

	localparam logic [2:0] REG_SAMPLE_INTERVAL   = 3'd0;
	localparam logic [2:0] REG_INITIAL_ERROR     = 3'd1;
	localparam logic [2:0] REG_PROCESS_NOISE     = 3'd2;
	localparam logic [2:0] REG_MEASUREMENT_NOISE = 3'd3;
	localparam logic [2:0] REG_THREE_STATE_MODE  = 3'd4;

	localparam logic CMD_FILTER  = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	typedef struct packed {
		logic        clip;
		logic [31:0] val;
	} sat_t;

	typedef struct packed {
		logic          vld;
		logic          first;
		logic          last;
		logic          neg;
		logic          hsq;
		logic          use_alt;
		logic [31:0]   coef;
		logic [31:0]   alt;
		logic [31:0]   base;
		logic [AW-1:0] waddr;
	} uop_t;

	typedef struct packed {
		logic          wen;
		logic          hsq_wen;
		logic          clip;
		logic [AW-1:0] waddr;
		logic [31:0]   data;
	} mac_res_t;

	function automatic sat_t sat32(input logic signed [63:0] v);
		sat_t r;
		if (v > 64'sd2147483647) begin
			r.clip = 1'b1;
			r.val  = 32'h7fff_ffff;
		end else if (v < -64'sd2147483648) begin
			r.clip = 1'b1;
			r.val  = 32'h8000_0000;
		end else begin
			r.clip = 1'b0;
			r.val  = v[31:0];
		end
		return r;
	endfunction

	function automatic logic [AW-1:0] mat_addr(input logic [AW-1:0] base,
			input logic [1:0] row, input logic [1:0] col);
		return base + AW'({row, 1'b0}) + AW'(row) + AW'(col);
	endfunction

endpackage

`default_nettype wire

@@ design/kfca_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module kfca_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 33,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ design/kfca_div.sv @@
// Restoring divider producing one quotient bit per cycle on unsigned magnitudes.
`default_nettype none

module kfca_div (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [kfca_pkg::QW-1:0] dividend,
	input  wire logic [31:0]             divisor,
	output logic                         done,
	output logic [kfca_pkg::QW-1:0]      quotient
);

	logic [kfca_pkg::QW-1:0]     q_q;
	logic [31:0]                 r_q;
	logic [31:0]                 d_q;
	logic [kfca_pkg::QCNT_W-1:0] cnt_q;
	logic                        run_q;
	logic                        done_q;
	logic [32:0]                 rr;
	logic [32:0]                 rn;
	logic                        ge;

	always_comb begin
		rr = {r_q, q_q[kfca_pkg::QW-1]};
		ge = rr >= {1'b0, d_q};
		rn = ge ? rr - {1'b0, d_q} : rr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				q_q   <= dividend;
				r_q   <= '0;
				d_q   <= divisor;
				cnt_q <= kfca_pkg::QCNT_W'(kfca_pkg::QW);
				run_q <= 1'b1;
			end else if (run_q) begin
				q_q   <= {q_q[kfca_pkg::QW-2:0], ge};
				r_q   <= rn[31:0];
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == kfca_pkg::QCNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = q_q;

endmodule

`default_nettype wire

@@ design/kfca_mac.sv @@
// Two-stage multiply, round and accumulate datapath fed by one RAM word per cycle.
`default_nettype none

module kfca_mac (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire kfca_pkg::uop_t    uop,
	input  wire logic [31:0]       rdata,
	output kfca_pkg::mac_res_t     res,
	output logic                   busy
);

	localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (kfca_pkg::FRAC_BITS - 1);
	localparam logic signed [63:0] ROUND_ONE  = 64'sd1 <<< kfca_pkg::FRAC_BITS;

	kfca_pkg::uop_t     u_s1;
	kfca_pkg::uop_t     u_s2;
	logic signed [63:0] prod_s2;
	logic signed [63:0] acc_q;
	logic signed [31:0] b_s1;
	logic signed [63:0] term;
	logic signed [63:0] start_val;
	logic signed [63:0] acc_new;
	logic signed [63:0] hsq_full;
	kfca_pkg::sat_t     sat_a;
	kfca_pkg::sat_t     sat_h;

	always_comb begin
		b_s1      = u_s1.use_alt ? $signed(u_s1.alt) : $signed(rdata);
		term      = (prod_s2 + ROUND_HALF) >>> kfca_pkg::FRAC_BITS;
		start_val = u_s2.first ? $signed(64'(u_s2.base)) : acc_q;
		acc_new   = u_s2.neg ? start_val - term : start_val + term;
		hsq_full  = (prod_s2 + ROUND_ONE) >>> (kfca_pkg::FRAC_BITS + 1);
		sat_a     = kfca_pkg::sat32(acc_new);
		sat_h     = kfca_pkg::sat32(hsq_full);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_s1 <= '0;
			u_s2 <= '0;
		end else begin
			u_s1 <= uop;
			u_s2 <= u_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (u_s1.vld) begin
			prod_s2 <= 64'($signed(u_s1.coef)) * 64'(b_s1);
		end
		if (u_s2.vld) begin
			acc_q <= acc_new;
		end
	end

	always_comb begin
		res.wen     = u_s2.vld && u_s2.last && !u_s2.hsq;
		res.hsq_wen = u_s2.vld && u_s2.hsq;
		res.waddr   = u_s2.waddr;
		res.data    = u_s2.hsq ? sat_h.val : sat_a.val;
		res.clip    = u_s2.hsq ? (u_s2.vld && sat_h.clip)
		                       : (u_s2.vld && u_s2.last && sat_a.clip);
		busy        = u_s1.vld || u_s2.vld;
	end

endmodule

`default_nettype wire

@@ design/kalman_filter_const_accel.sv @@
// Top level: sequencer, configuration registers and output stage of the Kalman filter.
// One transaction is worked at a time. The time that a filter transaction takes is set by the
// restoring divider (once per gain) and by the single multiply-accumulate path, which
// reads one RAM word per cycle while the sequencer keeps issuing to it.
// Reset: registers take their default values; estimate entries read as zero and covariance
// entries as 65536 through per-entry valid flags, so there is no clearing pass.
`default_nettype none

module kalman_filter_const_accel (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               command,
	input  wire logic signed [31:0] measurement,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      est_position,
	output logic signed [31:0]      est_velocity,
	output logic signed [31:0]      est_acceleration,
	output logic signed [31:0]      gain_first,
	output logic signed [31:0]      gain_second,
	output logic signed [31:0]      gain_third,
	output logic                    saturated,
	input  wire logic               cfg_wr_en,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [30:0]        cfg_data
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_HSQ  = 4'd1;
	localparam logic [3:0] ST_XP   = 4'd2;
	localparam logic [3:0] ST_TP   = 4'd3;
	localparam logic [3:0] ST_PP   = 4'd4;
	localparam logic [3:0] ST_RDS  = 4'd5;
	localparam logic [3:0] ST_GETS = 4'd6;
	localparam logic [3:0] ST_RDY  = 4'd7;
	localparam logic [3:0] ST_GETY = 4'd8;
	localparam logic [3:0] ST_RDK  = 4'd9;
	localparam logic [3:0] ST_LDK  = 4'd10;
	localparam logic [3:0] ST_DIV  = 4'd11;
	localparam logic [3:0] ST_XU   = 4'd12;
	localparam logic [3:0] ST_PU   = 4'd13;
	localparam logic [3:0] ST_FIN  = 4'd14;

	logic [30:0] dt_q;
	logic [30:0] ie_q;
	logic [30:0] pn_q;
	logic [30:0] mn_q;
	logic        mode_q;

	logic [3:0]  state_q;
	logic [1:0]  i_q;
	logic [1:0]  j_q;
	logic [1:0]  c_q;
	logic        run_q;
	logic [kfca_pkg::STATE_ENTRIES-1:0] valid_q;
	logic [31:0] init_q;
	logic [31:0] hsq_q;
	logic [31:0] y_q;
	logic [31:0] s_q;
	logic [31:0] z_q;
	logic        szero_q;
	logic        negk_q;
	logic        clip_q;
	logic [31:0] k_q [3];
	logic [31:0] est_q [3];

	logic        out_valid_q;
	logic [31:0] est_pos_q;
	logic [31:0] est_vel_q;
	logic [31:0] est_acc_q;
	logic [31:0] gain_0_q;
	logic [31:0] gain_1_q;
	logic [31:0] gain_2_q;
	logic        sat_q;

	logic [1:0]  n_act;
	logic [1:0]  m;
	logic        accept;
	logic        issue;
	logic        fin_go;
	logic        mac_busy;
	logic        div_start;
	logic        div_done;
	logic [kfca_pkg::QW-1:0] div_dividend;
	logic [kfca_pkg::QW-1:0] div_quot;
	logic [31:0] p_abs;
	logic [31:0] s_abs;
	logic [63:0] qz;
	logic signed [63:0] qv;
	logic [kfca_pkg::AW-1:0] raddr;
	logic [31:0] rdata;
	kfca_pkg::uop_t     uop;
	kfca_pkg::mac_res_t res;
	kfca_pkg::sat_t     sat_s;
	kfca_pkg::sat_t     sat_y;
	kfca_pkg::sat_t     sat_k;

	function automatic logic [31:0] a_coef(input logic [1:0] row, input logic [1:0] col,
			input logic [31:0] dt, input logic [31:0] hs);
		logic [2:0] r3;
		logic [2:0] c3;
		r3 = {1'b0, row};
		c3 = {1'b0, col};
		if (c3 == r3) begin
			return kfca_pkg::ONE;
		end else if (c3 == r3 + 3'd1) begin
			return dt;
		end else if (c3 == r3 + 3'd2) begin
			return hs;
		end
		return '0;
	endfunction

	assign n_act    = mode_q ? 2'(kfca_pkg::STATE_COUNT) : 2'd1;
	assign m        = n_act - 2'd1;
	assign in_stall = state_q != ST_IDLE;
	assign accept   = in_valid && !in_stall;
	assign issue    = run_q || !mac_busy;
	assign fin_go   = state_q == ST_FIN && !mac_busy && (!out_valid_q || !out_stall);

	always_comb begin
		uop   = '0;
		raddr = '0;
		case (state_q)
			ST_HSQ: begin
				uop.vld     = !mac_busy;
				uop.first   = 1'b1;
				uop.last    = 1'b1;
				uop.hsq     = 1'b1;
				uop.coef    = {1'b0, dt_q};
				uop.use_alt = 1'b1;
				uop.alt     = {1'b0, dt_q};
				raddr       = kfca_pkg::XP_BASE;
			end
			ST_XP: begin
				uop.vld   = issue;
				uop.first = c_q == i_q;
				uop.last  = c_q == m;
				uop.coef  = a_coef(i_q, c_q, {1'b0, dt_q}, hsq_q);
				uop.waddr = kfca_pkg::XP_BASE + kfca_pkg::AW'(i_q);
				raddr     = kfca_pkg::X_BASE + kfca_pkg::AW'(c_q);
			end
			ST_TP: begin
				uop.vld   = issue;
				uop.first = c_q == i_q;
				uop.last  = c_q == m;
				uop.coef  = a_coef(i_q, c_q, {1'b0, dt_q}, hsq_q);
				uop.waddr = kfca_pkg::mat_addr(kfca_pkg::T_BASE, i_q, j_q);
				raddr     = kfca_pkg::mat_addr(kfca_pkg::P_BASE, c_q, j_q);
			end
			ST_PP: begin
				uop.vld   = issue;
				uop.first = c_q == j_q;
				uop.last  = c_q == m;
				uop.coef  = a_coef(j_q, c_q, {1'b0, dt_q}, hsq_q);
				uop.base  = {1'b0, pn_q};
				uop.waddr = kfca_pkg::mat_addr(kfca_pkg::PP_BASE, i_q, j_q);
				raddr     = kfca_pkg::mat_addr(kfca_pkg::T_BASE, i_q, c_q);
			end
			ST_XU: begin
				uop.vld   = issue;
				uop.first = c_q == 2'd0;
				uop.last  = c_q == 2'd1;
				uop.waddr = kfca_pkg::X_BASE + kfca_pkg::AW'(i_q);
				if (c_q == 2'd0) begin
					uop.coef = kfca_pkg::ONE;
					raddr    = kfca_pkg::XP_BASE + kfca_pkg::AW'(i_q);
				end else begin
					uop.coef    = k_q[i_q];
					uop.use_alt = 1'b1;
					uop.alt     = y_q;
					raddr       = kfca_pkg::XP_BASE;
				end
			end
			ST_PU: begin
				uop.vld   = issue;
				uop.first = c_q == 2'd0;
				uop.last  = c_q == 2'd1;
				uop.waddr = kfca_pkg::mat_addr(kfca_pkg::P_BASE, i_q, j_q);
				if (c_q == 2'd0) begin
					uop.coef = kfca_pkg::ONE;
					raddr    = kfca_pkg::mat_addr(kfca_pkg::PP_BASE, i_q, j_q);
				end else begin
					uop.coef = k_q[i_q];
					uop.neg  = 1'b1;
					raddr    = kfca_pkg::mat_addr(kfca_pkg::PP_BASE, m, j_q);
				end
			end
			ST_RDS: raddr = kfca_pkg::mat_addr(kfca_pkg::PP_BASE, m, m);
			ST_RDY: raddr = kfca_pkg::XP_BASE + kfca_pkg::AW'(m);
			ST_RDK: raddr = kfca_pkg::mat_addr(kfca_pkg::PP_BASE, i_q, m);
			default: raddr = '0;
		endcase
		// Entries never written since reset or restart read as their initial values.
		if (uop.vld && !uop.use_alt && raddr < kfca_pkg::AW'(kfca_pkg::STATE_ENTRIES)
				&& !valid_q[raddr[kfca_pkg::SE_W-1:0]]) begin
			uop.use_alt = 1'b1;
			uop.alt     = (raddr < kfca_pkg::P_BASE) ? 32'd0 : init_q;
		end
	end

	always_comb begin
		sat_s        = kfca_pkg::sat32($signed(64'($signed(rdata)) + 64'(mn_q)));
		sat_y        = kfca_pkg::sat32(64'($signed(z_q)) - 64'($signed(rdata)));
		p_abs        = rdata[31] ? 32'd0 - rdata : rdata;
		s_abs        = s_q[31] ? 32'd0 - s_q : s_q;
		div_dividend = {p_abs, {kfca_pkg::FRAC_BITS{1'b0}}};
		div_start    = state_q == ST_LDK;
		qz           = 64'(div_quot);
		qv           = negk_q ? -$signed(qz) : $signed(qz);
		sat_k        = kfca_pkg::sat32(qv);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q   <= 31'd655;
			ie_q   <= 31'd65536;
			pn_q   <= 31'd655;
			mn_q   <= 31'd65536;
			mode_q <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				kfca_pkg::REG_SAMPLE_INTERVAL:   dt_q   <= cfg_data;
				kfca_pkg::REG_INITIAL_ERROR:     ie_q   <= cfg_data;
				kfca_pkg::REG_PROCESS_NOISE:     pn_q   <= cfg_data;
				kfca_pkg::REG_MEASUREMENT_NOISE: mn_q   <= cfg_data;
				kfca_pkg::REG_THREE_STATE_MODE:  mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			c_q         <= '0;
			run_q       <= 1'b0;
			valid_q     <= '0;
			init_q      <= 32'd65536;
			clip_q      <= 1'b0;
			szero_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (res.wen && res.waddr < kfca_pkg::AW'(kfca_pkg::STATE_ENTRIES)) begin
				valid_q[res.waddr[kfca_pkg::SE_W-1:0]] <= 1'b1;
			end
			if (res.clip) begin
				clip_q <= 1'b1;
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						clip_q <= 1'b0;
						i_q    <= '0;
						j_q    <= '0;
						c_q    <= '0;
						run_q  <= 1'b0;
						if (command == kfca_pkg::CMD_RESTART) begin
							valid_q <= '0;
							init_q  <= {1'b0, ie_q};
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_HSQ;
						end
					end
				end
				ST_HSQ: begin
					if (uop.vld) begin
						state_q <= ST_XP;
					end
				end
				ST_XP: begin
					if (uop.vld) begin
						run_q <= !(c_q == m && i_q == m);
						if (c_q == m) begin
							if (i_q == m) begin
								state_q <= ST_TP;
								i_q     <= '0;
								c_q     <= '0;
							end else begin
								i_q <= i_q + 2'd1;
								c_q <= i_q + 2'd1;
							end
						end else begin
							c_q <= c_q + 2'd1;
						end
					end
				end
				ST_TP: begin
					if (uop.vld) begin
						run_q <= !(c_q == m && j_q == m && i_q == m);
						if (c_q == m) begin
							if (j_q == m) begin
								if (i_q == m) begin
									state_q <= ST_PP;
									i_q     <= '0;
									j_q     <= '0;
									c_q     <= '0;
								end else begin
									i_q <= i_q + 2'd1;
									j_q <= '0;
									c_q <= i_q + 2'd1;
								end
							end else begin
								j_q <= j_q + 2'd1;
								c_q <= i_q;
							end
						end else begin
							c_q <= c_q + 2'd1;
						end
					end
				end
				ST_PP: begin
					if (uop.vld) begin
						run_q <= !(c_q == m && j_q == m && i_q == m);
						if (c_q == m) begin
							if (j_q == m) begin
								if (i_q == m) begin
									state_q <= ST_RDS;
									i_q     <= '0;
									j_q     <= '0;
									c_q     <= '0;
								end else begin
									i_q <= i_q + 2'd1;
									j_q <= '0;
									c_q <= '0;
								end
							end else begin
								j_q <= j_q + 2'd1;
								c_q <= j_q + 2'd1;
							end
						end else begin
							c_q <= c_q + 2'd1;
						end
					end
				end
				ST_RDS: begin
					if (!mac_busy) begin
						state_q <= ST_GETS;
					end
				end
				ST_GETS: begin
					szero_q <= sat_s.val == 32'd0;
					if (sat_s.clip || sat_s.val == 32'd0) begin
						clip_q <= 1'b1;
					end
					state_q <= ST_RDY;
				end
				ST_RDY: state_q <= ST_GETY;
				ST_GETY: begin
					if (sat_y.clip) begin
						clip_q <= 1'b1;
					end
					i_q     <= '0;
					c_q     <= '0;
					state_q <= szero_q ? ST_XU : ST_RDK;
				end
				ST_RDK: state_q <= ST_LDK;
				ST_LDK: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						if (sat_k.clip) begin
							clip_q <= 1'b1;
						end
						if (i_q == m) begin
							i_q     <= '0;
							state_q <= ST_XU;
						end else begin
							i_q     <= i_q + 2'd1;
							state_q <= ST_RDK;
						end
					end
				end
				ST_XU: begin
					if (uop.vld) begin
						run_q <= !(c_q == 2'd1 && i_q == m);
						if (c_q == 2'd1) begin
							c_q <= '0;
							if (i_q == m) begin
								state_q <= ST_PU;
								i_q     <= '0;
								j_q     <= '0;
							end else begin
								i_q <= i_q + 2'd1;
							end
						end else begin
							c_q <= 2'd1;
						end
					end
				end
				ST_PU: begin
					if (uop.vld) begin
						run_q <= !(c_q == 2'd1 && j_q == m && i_q == m);
						if (c_q == 2'd1) begin
							c_q <= '0;
							if (j_q == m) begin
								j_q <= '0;
								if (i_q == m) begin
									state_q <= ST_FIN;
									i_q     <= '0;
								end else begin
									i_q <= i_q + 2'd1;
								end
							end else begin
								j_q <= j_q + 2'd1;
							end
						end else begin
							c_q <= 2'd1;
						end
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res.hsq_wen) begin
			hsq_q <= res.data;
		end
		if (res.wen && res.waddr < kfca_pkg::P_BASE) begin
			est_q[res.waddr[1:0]] <= res.data;
		end
		if (accept) begin
			z_q      <= measurement;
			k_q[0]   <= '0;
			k_q[1]   <= '0;
			k_q[2]   <= '0;
			est_q[0] <= '0;
			est_q[1] <= '0;
			est_q[2] <= '0;
		end
		if (state_q == ST_GETS) begin
			s_q <= sat_s.val;
		end
		if (state_q == ST_GETY) begin
			y_q <= sat_y.val;
		end
		if (state_q == ST_LDK) begin
			negk_q <= rdata[31] ^ s_q[31];
		end
		if (state_q == ST_DIV && div_done) begin
			k_q[i_q] <= sat_k.val;
		end
		if (fin_go) begin
			est_pos_q <= est_q[0];
			est_vel_q <= (n_act > 2'd1) ? est_q[1] : 32'd0;
			est_acc_q <= (n_act > 2'd2) ? est_q[2] : 32'd0;
			gain_0_q  <= k_q[0];
			gain_1_q  <= (n_act > 2'd1) ? k_q[1] : 32'd0;
			gain_2_q  <= (n_act > 2'd2) ? k_q[2] : 32'd0;
			sat_q     <= clip_q;
		end
	end

	kfca_ram #(
		.WIDTH (32),
		.DEPTH (kfca_pkg::RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (res.wen),
		.waddr (res.waddr),
		.wdata (res.data),
		.raddr (raddr),
		.rdata (rdata)
	);

	kfca_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.uop    (uop),
		.rdata  (rdata),
		.res    (res),
		.busy   (mac_busy)
	);

	kfca_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (s_abs),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign out_valid        = out_valid_q;
	assign est_position     = est_pos_q;
	assign est_velocity     = est_vel_q;
	assign est_acceleration = est_acc_q;
	assign gain_first       = gain_0_q;
	assign gain_second      = gain_1_q;
	assign gain_third       = gain_2_q;
	assign saturated        = sat_q;

endmodule

`default_nettype wire
